[design/tp_pkg.sv]
// tp_pkg: shared types and constants for the timer pool.
// Operation and result codes, field widths, controller/datapath command structs.
// No dependencies.
`default_nettype none

package tp_pkg;

  localparam int OP_W    = 3;
  localparam int ID_W    = 3;
  localparam int MODE_W  = 2;
  localparam int CNT_W   = 16;
  localparam int KIND_W  = 3;
  localparam int SLOT_ID_W = 4;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC      = 3'd0,
    OP_FREE       = 3'd1,
    OP_SET_RELOAD = 3'd2,
    OP_START      = 3'd3,
    OP_TICK       = 3'd4,
    OP_READ       = 3'd5
  } op_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_GRANTED = 3'd0,
    KIND_DONE    = 3'd1,
    KIND_FAILED  = 3'd2,
    KIND_FIRED   = 3'd3,
    KIND_COUNT   = 3'd4
  } kind_t;

  localparam logic [SLOT_ID_W-1:0] NO_SLOT     = 4'd8;
  localparam logic [MODE_W-1:0]    MODE_ONESHOT = 2'd0;
  localparam logic [MODE_W-1:0]    MODE_CYCLIC  = 2'd1;

  // controller -> datapath
  typedef struct packed {
    logic latch;       // capture input item
    logic exec_op;     // run a non-tick operation, write result
    logic tick_step;   // process one slot of a tick
    logic tick_close;  // write closing done result of a tick
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_tick;     // latched item is a tick
    logic step_fires;  // current tick step produces a fired result
  } sts_t;

endpackage

`default_nettype wire

[design/timer_pool_with_oneshot_and_cyclic.sv]
// timer_pool_with_oneshot_and_cyclic: top level of the countdown timer pool.
// Joins controller tp_ctrl and datapath tp_dp. Uses tp_pkg.
//
// A pool of NUM_SLOTS (1..8) countdown timers. Each input item carries one
// operation: allocate (lowest free slot), free, set reload, start (allocate
// and load mode, delay, reload and callback flag), tick, or read count.
// Every operation except tick returns one result item: the item is latched,
// then its result is written to the output register once the output side is
// free. A tick walks the slots one per cycle while the output side is free,
// lowest first, returning a fired item for each slot that expires with
// a callback in one-shot or cyclic mode, then a closing done item with
// slot_id 8. The controller's step counter drives the slot walk, and a stall
// on the output holds it. One item is in work at a time; a new item is
// accepted as soon as the previous one's last result sits in the output
// register, even if it has not yet been taken. last_of_run marks the final
// result item of each input item. Failures (pool full, slot out of range,
// unknown operation) answer failed with slot_id 8 and leave state untouched.
`default_nettype none

module timer_pool_with_oneshot_and_cyclic #(
  parameter int NUM_SLOTS = 8
) (
  input  wire                          clk,
  input  wire                          rst_n,
  // input items
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire [tp_pkg::OP_W-1:0]       in_operation,
  input  wire [tp_pkg::ID_W-1:0]       in_timer_id,
  input  wire [tp_pkg::MODE_W-1:0]     in_timer_mode,
  input  wire [tp_pkg::CNT_W-1:0]      in_delay_value,
  input  wire [tp_pkg::CNT_W-1:0]      in_reload_value,
  input  wire                          in_has_callback,
  // result items
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic [tp_pkg::KIND_W-1:0]    out_result_kind,
  output logic [tp_pkg::SLOT_ID_W-1:0] out_slot_id,
  output logic [tp_pkg::CNT_W-1:0]     out_count_value,
  output logic                         out_pending_flag,
  output logic                         out_last_of_run
);
  import tp_pkg::*;

  localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  cmd_t          cmd;
  sts_t          sts;
  logic [SW-1:0] step_idx;

  // sequencing: accept, execute, tick walk, closing result
  tp_ctrl #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd),
    .step_idx  (step_idx)
  );

  // slot registers, allocation bitmap and result register
  tp_dp #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .step_idx         (step_idx),
    .sts              (sts),
    .in_operation     (in_operation),
    .in_timer_id      (in_timer_id),
    .in_timer_mode    (in_timer_mode),
    .in_delay_value   (in_delay_value),
    .in_reload_value  (in_reload_value),
    .in_has_callback  (in_has_callback),
    .out_result_kind  (out_result_kind),
    .out_slot_id      (out_slot_id),
    .out_count_value  (out_count_value),
    .out_pending_flag (out_pending_flag),
    .out_last_of_run  (out_last_of_run)
  );

endmodule

`default_nettype wire

[design/tp_ctrl.sv]
// tp_ctrl: sequencing state machine of the timer pool.
// Drives input ready, output valid and datapath commands. Uses tp_pkg.
`default_nettype none

module tp_ctrl #(
  parameter int NUM_SLOTS = 8
) (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  wire             out_ready,
  input  tp_pkg::sts_t    sts,
  output tp_pkg::cmd_t    cmd,
  output logic [((NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1)-1:0] step_idx
);
  import tp_pkg::*;

  localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam logic [SW-1:0] LAST_IDX = SW'(NUM_SLOTS - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_TICK,
    ST_CLOSE
  } state_t;

  state_t          state_r, state_nxt;
  logic [SW-1:0]   cnt_r, cnt_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            out_free;
  logic            emit;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign step_idx  = cnt_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    emit      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          if (sts.is_tick) begin
            cnt_nxt   = '0;
            state_nxt = ST_TICK;
          end else begin
            cmd.exec_op = 1'b1;
            emit        = 1'b1;
            state_nxt   = ST_IDLE;
          end
        end
      end
      ST_TICK: begin
        if (out_free) begin
          cmd.tick_step = 1'b1;
          emit          = sts.step_fires;
          if (cnt_r == LAST_IDX) begin
            state_nxt = ST_CLOSE;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      end
      ST_CLOSE: begin
        if (out_free) begin
          cmd.tick_close = 1'b1;
          emit           = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    out_valid_nxt = (out_valid_r && !out_ready) || emit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

[design/tp_dp.sv]
// tp_dp: datapath of the timer pool: slot state, latched item, result register.
// Acts on commands from tp_ctrl. Uses tp_pkg.
`default_nettype none

module tp_dp #(
  parameter int NUM_SLOTS = 8
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  tp_pkg::cmd_t                     cmd,
  input  wire [((NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1)-1:0] step_idx,
  output tp_pkg::sts_t                     sts,
  input  wire [tp_pkg::OP_W-1:0]           in_operation,
  input  wire [tp_pkg::ID_W-1:0]           in_timer_id,
  input  wire [tp_pkg::MODE_W-1:0]         in_timer_mode,
  input  wire [tp_pkg::CNT_W-1:0]          in_delay_value,
  input  wire [tp_pkg::CNT_W-1:0]          in_reload_value,
  input  wire                              in_has_callback,
  output logic [tp_pkg::KIND_W-1:0]        out_result_kind,
  output logic [tp_pkg::SLOT_ID_W-1:0]     out_slot_id,
  output logic [tp_pkg::CNT_W-1:0]         out_count_value,
  output logic                             out_pending_flag,
  output logic                             out_last_of_run
);
  import tp_pkg::*;

  localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  // latched item
  logic [OP_W-1:0]   op_r;
  logic [ID_W-1:0]   id_r;
  logic [MODE_W-1:0] mode_r;
  logic [CNT_W-1:0]  delay_r;
  logic [CNT_W-1:0]  reload_r;
  logic              cb_r;

  // slot state
  logic [NUM_SLOTS-1:0] in_use_r;
  logic [NUM_SLOTS-1:0] pend_r;
  logic [CNT_W-1:0]     rem_r  [NUM_SLOTS];
  logic [CNT_W-1:0]     rld_r  [NUM_SLOTS];
  logic [MODE_W-1:0]    smode_r[NUM_SLOTS];
  logic [NUM_SLOTS-1:0] scb_r;

  // result register
  logic [KIND_W-1:0]    kind_r;
  logic [SLOT_ID_W-1:0] slot_r;
  logic [CNT_W-1:0]     cntv_r;
  logic                 pflag_r;
  logic                 last_r;

  logic          free_found;
  logic [SW-1:0] free_idx;
  logic          id_ok;
  logic [SW-1:0] id_idx;
  logic          t_active;
  logic [CNT_W-1:0] t_dec;
  logic          t_zero;
  logic          t_mode_ok;

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (!free_found && !in_use_r[i]) begin
        free_found = 1'b1;
        free_idx   = SW'(i);
      end
    end
  end

  assign id_ok  = ({1'b0, id_r} < SLOT_ID_W'(NUM_SLOTS));
  assign id_idx = id_r[SW-1:0];

  // tick step on slot step_idx
  assign t_active  = in_use_r[step_idx] && (rem_r[step_idx] != '0);
  assign t_dec     = rem_r[step_idx] - 1'b1;
  assign t_zero    = (t_dec == '0);
  assign t_mode_ok = (smode_r[step_idx] == MODE_ONESHOT) ||
                     (smode_r[step_idx] == MODE_CYCLIC);

  assign sts = '{is_tick:    (op_r == OP_TICK),
                 step_fires: (t_active && t_zero && scb_r[step_idx] && t_mode_ok)};

  function automatic logic [SLOT_ID_W-1:0] ext_id(input logic [SW-1:0] v);
    ext_id = {{(SLOT_ID_W-SW){1'b0}}, v};
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_use_r <= '0;
      pend_r   <= '0;
      scb_r    <= '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        rem_r[i]   <= '0;
        rld_r[i]   <= '0;
        smode_r[i] <= '0;
      end
    end else begin
      if (cmd.exec_op) begin
        case (op_t'(op_r))
          OP_ALLOC: begin
            if (free_found) begin
              in_use_r[free_idx] <= 1'b1;
            end
          end
          OP_FREE: begin
            if (id_ok) begin
              in_use_r[id_idx] <= 1'b0;
              pend_r[id_idx]   <= 1'b0;
              rem_r[id_idx]    <= '0;
              scb_r[id_idx]    <= 1'b0;
            end
          end
          OP_SET_RELOAD: begin
            if (id_ok) begin
              rld_r[id_idx] <= reload_r;
            end
          end
          OP_START: begin
            if (free_found) begin
              in_use_r[free_idx] <= 1'b1;
              pend_r[free_idx]   <= 1'b0;
              smode_r[free_idx]  <= mode_r;
              scb_r[free_idx]    <= cb_r;
              rld_r[free_idx]    <= reload_r;
              rem_r[free_idx]    <= delay_r;
            end
          end
          default: ;
        endcase
      end else if (cmd.tick_step && t_active) begin
        if (!t_zero) begin
          rem_r[step_idx] <= t_dec;
        end else if (!scb_r[step_idx]) begin
          // no callback: parks at zero with pending set
          rem_r[step_idx]  <= t_dec;
          pend_r[step_idx] <= 1'b1;
        end else if (smode_r[step_idx] == MODE_CYCLIC) begin
          pend_r[step_idx] <= 1'b0;
          rem_r[step_idx]  <= rld_r[step_idx];
        end else begin
          // one-shot and other modes free the slot
          rem_r[step_idx]    <= t_dec;
          in_use_r[step_idx] <= 1'b0;
          pend_r[step_idx]   <= 1'b0;
          scb_r[step_idx]    <= 1'b0;
        end
      end
    end
  end

  // latched item and result payload: no reset needed
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r     <= in_operation;
      id_r     <= in_timer_id;
      mode_r   <= in_timer_mode;
      delay_r  <= in_delay_value;
      reload_r <= in_reload_value;
      cb_r     <= in_has_callback;
    end
    if (cmd.exec_op) begin
      last_r <= 1'b1;
      case (op_t'(op_r))
        OP_ALLOC, OP_START: begin
          kind_r  <= free_found ? KIND_GRANTED : KIND_FAILED;
          slot_r  <= free_found ? ext_id(free_idx) : NO_SLOT;
          cntv_r  <= '0;
          pflag_r <= 1'b0;
        end
        OP_FREE, OP_SET_RELOAD: begin
          kind_r  <= id_ok ? KIND_DONE : KIND_FAILED;
          slot_r  <= id_ok ? {1'b0, id_r} : NO_SLOT;
          cntv_r  <= '0;
          pflag_r <= 1'b0;
        end
        OP_READ: begin
          kind_r  <= id_ok ? KIND_COUNT : KIND_FAILED;
          slot_r  <= id_ok ? {1'b0, id_r} : NO_SLOT;
          cntv_r  <= id_ok ? rem_r[id_idx] : '0;
          pflag_r <= id_ok && pend_r[id_idx];
        end
        default: begin
          kind_r  <= KIND_FAILED;
          slot_r  <= NO_SLOT;
          cntv_r  <= '0;
          pflag_r <= 1'b0;
        end
      endcase
    end else if (cmd.tick_step && sts.step_fires) begin
      kind_r  <= KIND_FIRED;
      slot_r  <= ext_id(step_idx);
      cntv_r  <= '0;
      pflag_r <= 1'b0;
      last_r  <= 1'b0;
    end else if (cmd.tick_close) begin
      kind_r  <= KIND_DONE;
      slot_r  <= NO_SLOT;
      cntv_r  <= '0;
      pflag_r <= 1'b0;
      last_r  <= 1'b1;
    end
  end

  assign out_result_kind  = kind_r;
  assign out_slot_id      = slot_r;
  assign out_count_value  = cntv_r;
  assign out_pending_flag = pflag_r;
  assign out_last_of_run  = last_r;

endmodule

`default_nettype wire

[design/tp_chk.sv]
// tp_chk: port-level checks for the timer pool, bound to the top level.
// Uses tp_pkg result codes.
`default_nettype none

module tp_chk (
  input wire                          clk,
  input wire                          rst_n,
  input wire                          in_valid,
  input wire                          in_ready,
  input wire                          out_valid,
  input wire                          out_ready,
  input wire [tp_pkg::KIND_W-1:0]     out_result_kind,
  input wire [tp_pkg::SLOT_ID_W-1:0]  out_slot_id,
  input wire [tp_pkg::CNT_W-1:0]      out_count_value,
  input wire                          out_pending_flag,
  input wire                          out_last_of_run
);
  import tp_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_kind) &&
                                $stable(out_slot_id) && $stable(out_last_of_run))
    else $error("result changed while stalled");

  // one item in work: busy right after an accept
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted two items back to back");

  // fired items never close a run, every other kind does
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_result_kind == KIND_FIRED) != out_last_of_run))
    else $error("last_of_run inconsistent with result kind");

  // count and flag only on count reports
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_result_kind != KIND_COUNT) |->
      (out_count_value == '0) && !out_pending_flag)
    else $error("count or flag set outside count report");

  // failures name no slot
  a_fail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_result_kind == KIND_FAILED) |-> out_slot_id == NO_SLOT)
    else $error("failed result names a slot");

endmodule

bind timer_pool_with_oneshot_and_cyclic tp_chk u_chk (.*);

`default_nettype wire
